// ----- rtl/lcs_pkg.sv -----
// shared constants, types and helper functions for the line centroid steering unit
package lcs_pkg;

   // row geometry
   localparam int ROW_WIDTH = 320;
   localparam int COL_W     = $clog2(ROW_WIDTH + 1);
   localparam int CNT_W     = COL_W;
   localparam int SUM_RAW_W = $clog2(ROW_WIDTH * (ROW_WIDTH - 1) / 2 + 1);
   localparam int SUM_W     = (SUM_RAW_W < 2) ? 2 : SUM_RAW_W;
   localparam int STEP_W    = $clog2(SUM_W);

   // arithmetic widths
   localparam int WIDE_W    = (COL_W > 9) ? COL_W : 9;
   localparam int ERR_W     = WIDE_W + 1;
   localparam int GAIN_W    = 10;
   localparam int PROD_W    = WIDE_W + GAIN_W;
   localparam int MAG_W     = PROD_W - 8;
   localparam int SPD_W     = MAG_W + 2;

   // register port
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 10;

   localparam logic [CSR_IDX_W-1:0] REG_WHITE_THRESHOLD = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_MIN_LINE_PIXELS = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_CENTER_COLUMN   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_GAIN_Q8         = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_BASE_SPEED      = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_REVERSE_SPEED   = 3'd5;

   // register reset values
   localparam logic [7:0]        RST_WHITE_THRESHOLD = 8'd105;
   localparam logic [8:0]        RST_MIN_LINE_PIXELS = 9'd15;
   localparam logic [8:0]        RST_CENTER_COLUMN   = 9'd160;
   localparam logic [GAIN_W-1:0] RST_GAIN_Q8         = 10'd230;
   localparam logic [8:0]        RST_BASE_SPEED      = 9'd35;
   localparam logic [8:0]        RST_REVERSE_SPEED   = 9'h1DD;

   // drive mode codes
   localparam logic [1:0] MODE_REVERSE = 2'd0;
   localparam logic [1:0] MODE_LEFT    = 2'd1;
   localparam logic [1:0] MODE_RIGHT   = 2'd2;
   localparam logic [1:0] MODE_HOLD    = 2'd3;

   localparam logic signed [SPD_W-1:0] SPD_MAX = SPD_W'(255);
   localparam logic signed [SPD_W-1:0] SPD_MIN = -SPD_W'(255);

   // controller states
   typedef enum logic [1:0] {
      ST_ACCUM,
      ST_DIVIDE,
      ST_MULTIPLY,
      ST_LOAD
   } lcs_state_type;

   // controller to datapath
   typedef struct packed {
      logic accept;
      logic row_done;
      logic div_step;
      logic mul_load;
      logic out_load;
   } lcs_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic div_last;
   } lcs_status_type;

   // clamp a speed sum to plus or minus 255
   function automatic logic signed [8:0] sat_speed(input logic signed [SPD_W-1:0] v);
      logic signed [8:0] r;
      if (v > SPD_MAX) begin
         r = 9'sd255;
      end else if (v < SPD_MIN) begin
         r = -9'sd255;
      end else begin
         r = v[8:0];
      end
      return r;
   endfunction

   // cap a count or column at 511 for the 9-bit outputs
   function automatic logic [8:0] cap511(input logic [WIDE_W-1:0] v);
      logic [8:0] r;
      if (v > WIDE_W'(511)) begin
         r = 9'd511;
      end else begin
         r = v[8:0];
      end
      return r;
   endfunction

endpackage

// ----- rtl/line_centroid_steering_unit.sv -----
// Pixels are taken one per cycle while accumulating; the last pixel of a row starts a bit-serial
// divide (one bit per sum bit), then a multiply state and a load state.
// The load state writes the result into the output register once the output is free.
// Input is stalled from the row's last pixel until that load, so no new row is taken meanwhile.
// Synchronous active-high reset clears accumulators, controller and output valid,
// and loads the settings registers with their default values.
module line_centroid_steering_unit (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_write_en,
   input  logic [lcs_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [lcs_pkg::CSR_DATA_W-1:0] csr_data,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic [7:0]                     req_pixel_value,
   input  logic                           req_row_end,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [1:0]                     rsp_drive_mode,
   output logic signed [8:0]              rsp_left_speed,
   output logic signed [8:0]              rsp_right_speed,
   output logic [8:0]                     rsp_line_column,
   output logic [8:0]                     rsp_line_count
);

   lcs_pkg::lcs_cmd_type    cmd;
   lcs_pkg::lcs_status_type status;

   // sequencing
   lcs_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_row_end (req_row_end),
      .req_stall   (req_stall),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .cmd         (cmd),
      .status      (status)
   );

   // arithmetic and storage
   lcs_datapath u_datapath (
      .clock           (clock),
      .reset           (reset),
      .csr_write_en    (csr_write_en),
      .csr_index       (csr_index),
      .csr_data        (csr_data),
      .req_pixel_value (req_pixel_value),
      .cmd             (cmd),
      .status          (status),
      .rsp_drive_mode  (rsp_drive_mode),
      .rsp_left_speed  (rsp_left_speed),
      .rsp_right_speed (rsp_right_speed),
      .rsp_line_column (rsp_line_column),
      .rsp_line_count  (rsp_line_count)
   );

endmodule

// ----- rtl/lcs_ctrl.sv -----
// controller state machine sequencing accumulate, divide, multiply and result load
module lcs_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic                   req_row_end,
   output logic                   req_stall,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output lcs_pkg::lcs_cmd_type    cmd,
   input  lcs_pkg::lcs_status_type status
);

   lcs_pkg::lcs_state_type state_ff, state_in;
   logic rsp_valid_ff, rsp_valid_in;

   // state and output valid registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= lcs_pkg::ST_ACCUM;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // next state and commands
   always_comb begin
      state_in     = state_ff;
      cmd          = '0;
      req_stall    = 1'b1;
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      case (state_ff)
         lcs_pkg::ST_ACCUM: begin
            req_stall  = 1'b0;
            cmd.accept = req_valid;
            if (req_valid && req_row_end) begin
               cmd.row_done = 1'b1;
               state_in     = lcs_pkg::ST_DIVIDE;
            end
         end
         lcs_pkg::ST_DIVIDE: begin
            cmd.div_step = 1'b1;
            if (status.div_last) begin
               state_in = lcs_pkg::ST_MULTIPLY;
            end
         end
         lcs_pkg::ST_MULTIPLY: begin
            cmd.mul_load = 1'b1;
            state_in     = lcs_pkg::ST_LOAD;
         end
         lcs_pkg::ST_LOAD: begin
            // wait until the output register is empty or being emptied
            if (!rsp_valid_ff || !rsp_stall) begin
               cmd.out_load = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = lcs_pkg::ST_ACCUM;
            end
         end
         default: begin
            state_in = lcs_pkg::ST_ACCUM;
         end
      endcase
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

// ----- rtl/lcs_datapath.sv -----
// datapath: settings registers, row accumulators, serial divider, gain multiply, result register
module lcs_datapath (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_write_en,
   input  logic [lcs_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [lcs_pkg::CSR_DATA_W-1:0]    csr_data,
   input  logic [7:0]                        req_pixel_value,
   input  lcs_pkg::lcs_cmd_type              cmd,
   output lcs_pkg::lcs_status_type           status,
   output logic [1:0]                        rsp_drive_mode,
   output logic signed [8:0]                 rsp_left_speed,
   output logic signed [8:0]                 rsp_right_speed,
   output logic [8:0]                        rsp_line_column,
   output logic [8:0]                        rsp_line_count
);

   // settings registers
   logic [7:0]                       threshold_ff;
   logic [8:0]                       min_pixels_ff;
   logic [8:0]                       center_ff;
   logic [lcs_pkg::GAIN_W-1:0]       gain_ff;
   logic signed [8:0]                base_ff;
   logic signed [8:0]                reverse_ff;

   // row accumulators
   logic [lcs_pkg::COL_W-1:0]        column_ff, column_in;
   logic [lcs_pkg::SUM_W-1:0]        sum_ff, sum_in;
   logic [lcs_pkg::CNT_W-1:0]        count_ff, count_in;

   // divider
   logic [lcs_pkg::SUM_W-1:0]        quo_ff, quo_in;
   logic [lcs_pkg::CNT_W-1:0]        rem_ff, rem_in;
   logic [lcs_pkg::CNT_W-1:0]        div_ff;
   logic [lcs_pkg::STEP_W-1:0]       step_ff, step_in;
   logic [lcs_pkg::CNT_W:0]          rem_shift;

   // multiply stage
   logic [lcs_pkg::WIDE_W-1:0]       col_wide;
   logic signed [lcs_pkg::ERR_W-1:0] err;
   logic [lcs_pkg::ERR_W-1:0]        err_abs;
   logic [lcs_pkg::PROD_W-1:0]       product;
   logic [lcs_pkg::MAG_W-1:0]        mag_ff;
   logic                             err_neg_ff;
   logic                             lost_ff;
   logic [8:0]                       col_out_ff;
   logic [8:0]                       cnt_out_ff;

   // result stage
   logic signed [lcs_pkg::SPD_W-1:0] base_ext;
   logic signed [lcs_pkg::SPD_W-1:0] boost;
   logic [1:0]                       mode_in;
   logic signed [8:0]                left_in, right_in;

   logic [1:0]                       mode_ff;
   logic signed [8:0]                left_ff, right_ff;
   logic [8:0]                       line_col_ff, line_cnt_ff;

   logic                             hit;
   logic                             in_row;

   // settings writes
   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff  <= lcs_pkg::RST_WHITE_THRESHOLD;
         min_pixels_ff <= lcs_pkg::RST_MIN_LINE_PIXELS;
         center_ff     <= lcs_pkg::RST_CENTER_COLUMN;
         gain_ff       <= lcs_pkg::RST_GAIN_Q8;
         base_ff       <= lcs_pkg::RST_BASE_SPEED;
         reverse_ff    <= lcs_pkg::RST_REVERSE_SPEED;
      end else if (csr_write_en) begin
         case (csr_index)
            lcs_pkg::REG_WHITE_THRESHOLD: threshold_ff  <= csr_data[7:0];
            lcs_pkg::REG_MIN_LINE_PIXELS: min_pixels_ff <= csr_data[8:0];
            lcs_pkg::REG_CENTER_COLUMN:   center_ff     <= csr_data[8:0];
            lcs_pkg::REG_GAIN_Q8:         gain_ff       <= csr_data;
            lcs_pkg::REG_BASE_SPEED:      base_ff       <= csr_data[8:0];
            lcs_pkg::REG_REVERSE_SPEED:   reverse_ff    <= csr_data[8:0];
            default: ;
         endcase
      end
   end

   // accumulate one pixel, pixels past the row width are ignored
   always_comb begin
      in_row    = column_ff < lcs_pkg::COL_W'(lcs_pkg::ROW_WIDTH);
      hit       = in_row && (req_pixel_value > threshold_ff);
      column_in = column_ff;
      sum_in    = sum_ff;
      count_in  = count_ff;
      if (cmd.accept && in_row) begin
         column_in = column_ff + lcs_pkg::COL_W'(1);
         if (hit) begin
            sum_in   = sum_ff + lcs_pkg::SUM_W'(column_ff);
            count_in = count_ff + lcs_pkg::CNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         column_ff <= '0;
         sum_ff    <= '0;
         count_ff  <= '0;
      end else if (cmd.row_done) begin
         column_ff <= '0;
         sum_ff    <= '0;
         count_ff  <= '0;
      end else begin
         column_ff <= column_in;
         sum_ff    <= sum_in;
         count_ff  <= count_in;
      end
   end

   // restoring divider, one quotient bit per cycle
   always_comb begin
      rem_shift = {rem_ff, quo_ff[lcs_pkg::SUM_W-1]};
      if (rem_shift >= {1'b0, div_ff}) begin
         rem_in = lcs_pkg::CNT_W'(rem_shift - {1'b0, div_ff});
         quo_in = {quo_ff[lcs_pkg::SUM_W-2:0], 1'b1};
      end else begin
         rem_in = rem_shift[lcs_pkg::CNT_W-1:0];
         quo_in = {quo_ff[lcs_pkg::SUM_W-2:0], 1'b0};
      end
      step_in = step_ff + lcs_pkg::STEP_W'(1);
   end

   assign status.div_last = step_ff == lcs_pkg::STEP_W'(lcs_pkg::SUM_W - 1);

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= '0;
      end else if (cmd.row_done) begin
         step_ff <= '0;
      end else if (cmd.div_step) begin
         step_ff <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.row_done) begin
         quo_ff <= sum_in;
         div_ff <= count_in;
         rem_ff <= '0;
      end else if (cmd.div_step) begin
         quo_ff <= quo_in;
         rem_ff <= rem_in;
      end
   end

   // error against the centre column and gain product
   always_comb begin
      if (div_ff == '0) begin
         col_wide = '0;
      end else begin
         col_wide = lcs_pkg::WIDE_W'(quo_ff[lcs_pkg::COL_W-1:0]);
      end
      err     = $signed({1'b0, lcs_pkg::WIDE_W'(center_ff)}) - $signed({1'b0, col_wide});
      err_abs = err[lcs_pkg::ERR_W-1] ? lcs_pkg::ERR_W'(-err) : lcs_pkg::ERR_W'(err);
      product = err_abs[lcs_pkg::WIDE_W-1:0] * gain_ff;
   end

   always_ff @(posedge clock) begin
      if (cmd.mul_load) begin
         mag_ff     <= product[lcs_pkg::PROD_W-1:8];
         err_neg_ff <= err[lcs_pkg::ERR_W-1];
         lost_ff    <= lcs_pkg::WIDE_W'(div_ff) < lcs_pkg::WIDE_W'(min_pixels_ff);
         col_out_ff <= lcs_pkg::cap511(col_wide);
         cnt_out_ff <= lcs_pkg::cap511(lcs_pkg::WIDE_W'(div_ff));
      end
   end

   // mode and saturated speeds
   always_comb begin
      base_ext = lcs_pkg::SPD_W'(base_ff);
      boost    = base_ext + $signed({2'b00, mag_ff});
      if (lost_ff) begin
         mode_in  = lcs_pkg::MODE_REVERSE;
         left_in  = lcs_pkg::sat_speed(lcs_pkg::SPD_W'(reverse_ff));
         right_in = left_in;
      end else if (mag_ff == '0) begin
         mode_in  = lcs_pkg::MODE_HOLD;
         left_in  = lcs_pkg::sat_speed(base_ext);
         right_in = left_in;
      end else if (err_neg_ff) begin
         mode_in  = lcs_pkg::MODE_RIGHT;
         left_in  = lcs_pkg::sat_speed(boost);
         right_in = lcs_pkg::sat_speed(base_ext);
      end else begin
         mode_in  = lcs_pkg::MODE_LEFT;
         left_in  = lcs_pkg::sat_speed(base_ext);
         right_in = lcs_pkg::sat_speed(boost);
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         mode_ff     <= mode_in;
         left_ff     <= left_in;
         right_ff    <= right_in;
         line_col_ff <= col_out_ff;
         line_cnt_ff <= cnt_out_ff;
      end
   end

   assign rsp_drive_mode  = mode_ff;
   assign rsp_left_speed  = left_ff;
   assign rsp_right_speed = right_ff;
   assign rsp_line_column = line_col_ff;
   assign rsp_line_count  = line_cnt_ff;

endmodule
